// File: rtl/core/smj_pkg.sv
`timescale 1ns / 1ps
package smj_pkg;

    typedef struct packed {
        logic               first;
        logic               mode;
        logic signed [16:0] value;
        logic [3:0]         row_index;
        logic               last;
    } smj_word_t;

    typedef struct packed {
        logic full;
        logic empty;
    } smj_qstat_t;

    localparam logic        MODE_FWD    = 1'b0;
    localparam logic        MODE_JAC    = 1'b1;
    localparam logic [16:0] LOG2E_Q16   = 17'd94548;
    localparam logic [63:0] LN2_Q32     = 64'd2977044472;
    localparam logic [20:0] SUM_MAX     = 21'h1FFFFF;
    localparam logic [15:0] PROB_MAX    = 16'hFFFF;
    localparam int          RES_MIN     = -131072;
    localparam int          RES_MAX     = 131071;
    localparam int          SHIFT_LIMIT = 16;

    // 2^(-k/2^tb) in Q1.16, Taylor series of exp(-z) in Q32
    function automatic logic [16:0] exp2_frac(input int unsigned k, input int unsigned tb);
        logic [63:0]        z;
        logic [63:0]        term;
        logic [127:0]       pr;
        logic signed [65:0] acc;
        logic [65:0]        r;
        z    = (64'(k) * LN2_Q32) >> tb;
        term = 64'd1 << 32;
        acc  = 66'sd4294967296;
        for (int n = 1; n <= 12; n++)
        begin
            pr   = 128'(term) * 128'(z);
            term = 64'(pr >> 32) / 64'(n);
            if (n % 2 == 1)
            begin
                acc = acc - $signed({2'b00, term});
            end
            else
            begin
                acc = acc + $signed({2'b00, term});
            end
        end
        if (acc < 0)
        begin
            acc = '0;
        end
        r = ($unsigned(acc) + 66'd32768) >> 16;
        return 17'(r);
    endfunction

endpackage

// File: rtl/core/smj_front.sv
`timescale 1ns / 1ps
module smj_front
    import smj_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               valid,
    output logic               stall,
    input  logic               mode,
    input  logic signed [16:0] value,
    input  logic [3:0]         row_index,
    input  logic               last,
    output smj_word_t          q_word,
    output logic               q_valid,
    input  logic               q_pop,
    output smj_qstat_t         q_stat
);

    smj_word_t   entry_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  fill_reg, fill_next;
    logic        first_reg, first_next;
    logic        push;
    logic        pop;
    smj_word_t   in_word;

    assign stall   = (fill_reg == 2'd2);
    assign push    = valid && !stall;
    assign pop     = q_pop && (fill_reg != 2'd0);
    assign q_valid = (fill_reg != 2'd0);
    assign q_word  = entry_reg[rd_ptr_reg];
    assign q_stat  = '{full: (fill_reg == 2'd2), empty: (fill_reg == 2'd0)};

    always_comb
    begin
        in_word = '{first: first_reg, mode: mode, value: value,
                    row_index: row_index, last: last};
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        first_next  = push ? last : first_reg;
        fill_next   = fill_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
            first_reg  <= 1'b1;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
            first_reg  <= first_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= in_word;
        end
    end

endmodule

// File: rtl/core/smj_back.sv
`timescale 1ns / 1ps
module smj_back
    import smj_pkg::*;
#(
    parameter int MAX_LEN        = 16,
    parameter int EXP_TABLE_BITS = 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  smj_word_t          q_word,
    input  logic               q_valid,
    output logic               q_pop,
    output logic               res_valid,
    input  logic               res_stall,
    output logic signed [17:0] result,
    output logic [3:0]         index,
    output logic               last_res
);

    localparam int CW    = $clog2(MAX_LEN + 1);
    localparam int AW    = $clog2(MAX_LEN);
    localparam int TAB_N = 1 << EXP_TABLE_BITS;
    localparam int TB    = EXP_TABLE_BITS;

    typedef enum logic [12:0] {
        ST_IDLE   = 13'b0000000000001,
        ST_RD     = 13'b0000000000010,
        ST_MUL    = 13'b0000000000100,
        ST_EXP    = 13'b0000000001000,
        ST_ACC    = 13'b0000000010000,
        ST_DSTART = 13'b0000000100000,
        ST_DIV    = 13'b0000001000000,
        ST_YRD    = 13'b0000010000000,
        ST_YGET   = 13'b0000100000000,
        ST_JRD    = 13'b0001000000000,
        ST_JMUL   = 13'b0010000000000,
        ST_JRND   = 13'b0100000000000,
        ST_EMIT   = 13'b1000000000000
    } state_t;

    logic [16:0] exp_tab [TAB_N];

    for (genvar g = 0; g < TAB_N; g++)
    begin : g_tab
        assign exp_tab[g] = exp2_frac(g, TB);
    end

    logic signed [16:0] mem [MAX_LEN];

    state_t             state_reg, state_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic signed [16:0] max_reg, max_next;
    logic [20:0]        sum_reg, sum_next;
    logic               mode_reg, mode_next;
    logic [CW-1:0]      j_reg, j_next;
    logic               pass_reg, pass_next;
    logic [3:0]         row_reg, row_next;
    logic [3:0]         it_reg, it_next;
    logic               ov_reg, ov_next;

    logic signed [16:0] rd_data_reg;
    logic [34:0]        prod_reg, prod_next;
    logic [16:0]        term_reg, term_next;
    logic signed [16:0] yi_reg, yi_next;
    logic signed [35:0] p_reg, p_next;
    logic [20:0]        rem_reg, rem_next;
    logic [15:0]        q_reg, q_next;
    logic signed [17:0] res_reg, res_next;
    logic signed [17:0] o_result_reg, o_result_next;
    logic [3:0]         o_index_reg, o_index_next;
    logic               o_last_reg, o_last_next;

    logic               wr_en;
    logic [AW-1:0]      rd_addr;
    logic signed [17:0] mag;
    logic [34:0]        t_val;
    logic [34:0]        t_int;
    logic [TB-1:0]      t_frac;
    logic [16:0]        exp_term;
    logic               j_last;
    logic [21:0]        acc_sum;
    logic [21:0]        rem2;
    logic signed [18:0] mul_b;
    logic signed [36:0] rnd;
    logic signed [20:0] rnd_q;
    logic               load_out;
    logic               row_ok;

    assign res_valid = ov_reg;
    assign result    = o_result_reg;
    assign index     = o_index_reg;
    assign last_res  = o_last_reg;

    always_comb
    begin
        mag      = 18'(max_reg) - 18'(rd_data_reg);
        t_val    = (prod_reg + (35'd1 << (23 - TB))) >> (24 - TB);
        t_int    = t_val >> TB;
        t_frac   = t_val[TB-1:0];
        exp_term = (t_int > 35'(SHIFT_LIMIT)) ? 17'd0 : (exp_tab[t_frac] >> t_int[4:0]);
        j_last   = ((CW+1)'(j_reg) + (CW+1)'(1)) == (CW+1)'(cnt_reg);
        acc_sum  = 22'(sum_reg) + 22'(term_reg);
        rem2     = {rem_reg, 1'b0};
        row_ok   = 32'(row_reg) < 32'(cnt_reg);
        mul_b    = (32'(j_reg) == 32'(row_reg)) ? (19'sd65536 - 19'(yi_reg))
                                                : -19'(rd_data_reg);
        rnd      = 37'(p_reg) + 37'sd32768;
        rnd_q    = 21'(rnd >>> 16);
        load_out = !ov_reg || !res_stall;
        rd_addr  = (state_reg == ST_YRD) ? AW'(row_reg) : j_reg[AW-1:0];

        state_next    = state_reg;
        cnt_next      = cnt_reg;
        max_next      = max_reg;
        sum_next      = sum_reg;
        mode_next     = mode_reg;
        j_next        = j_reg;
        pass_next     = pass_reg;
        row_next      = row_reg;
        it_next       = it_reg;
        ov_next       = ov_reg && res_stall;
        prod_next     = prod_reg;
        term_next     = term_reg;
        yi_next       = yi_reg;
        p_next        = p_reg;
        rem_next      = rem_reg;
        q_next        = q_reg;
        res_next      = res_reg;
        o_result_next = o_result_reg;
        o_index_next  = o_index_reg;
        o_last_next   = o_last_reg;
        wr_en         = 1'b0;
        q_pop         = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    if (q_word.first)
                    begin
                        mode_next = q_word.mode;
                    end
                    if (32'(cnt_reg) < MAX_LEN)
                    begin
                        wr_en    = 1'b1;
                        cnt_next = cnt_reg + CW'(1);
                        if (q_word.value > max_reg)
                        begin
                            max_next = q_word.value;
                        end
                    end
                    if (q_word.last)
                    begin
                        row_next  = q_word.row_index;
                        j_next    = '0;
                        pass_next = 1'b0;
                        state_next = (mode_next == MODE_FWD) ? ST_RD : ST_YRD;
                    end
                end
            end
            ST_RD:
            begin
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                prod_next  = 35'($unsigned(mag)) * 35'(LOG2E_Q16);
                state_next = ST_EXP;
            end
            ST_EXP:
            begin
                term_next  = exp_term;
                state_next = pass_reg ? ST_DSTART : ST_ACC;
            end
            ST_ACC:
            begin
                sum_next = (acc_sum > 22'(SUM_MAX)) ? SUM_MAX : acc_sum[20:0];
                if (j_last)
                begin
                    pass_next = 1'b1;
                    j_next    = '0;
                end
                else
                begin
                    j_next = j_reg + CW'(1);
                end
                state_next = ST_RD;
            end
            ST_DSTART:
            begin
                if (sum_reg == 21'd0 || 21'(term_reg) >= sum_reg)
                begin
                    res_next   = 18'(PROB_MAX);
                    state_next = ST_EMIT;
                end
                else
                begin
                    rem_next   = 21'(term_reg);
                    q_next     = '0;
                    it_next    = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (rem2 >= 22'(sum_reg))
                begin
                    rem_next = 21'(rem2 - 22'(sum_reg));
                    q_next   = {q_reg[14:0], 1'b1};
                end
                else
                begin
                    rem_next = rem2[20:0];
                    q_next   = {q_reg[14:0], 1'b0};
                end
                it_next = it_reg + 4'd1;
                if (it_reg == 4'd15)
                begin
                    res_next   = 18'(q_next);
                    state_next = ST_EMIT;
                end
            end
            ST_YRD:
            begin
                state_next = ST_YGET;
            end
            ST_YGET:
            begin
                yi_next    = row_ok ? rd_data_reg : 17'sd0;
                j_next     = '0;
                state_next = ST_JRD;
            end
            ST_JRD:
            begin
                state_next = ST_JMUL;
            end
            ST_JMUL:
            begin
                p_next     = 36'(yi_reg) * 36'(mul_b);
                state_next = ST_JRND;
            end
            ST_JRND:
            begin
                if (rnd_q < 21'(RES_MIN))
                begin
                    res_next = 18'(RES_MIN);
                end
                else if (rnd_q > 21'(RES_MAX))
                begin
                    res_next = 18'(RES_MAX);
                end
                else
                begin
                    res_next = 18'(rnd_q);
                end
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (load_out)
                begin
                    ov_next       = 1'b1;
                    o_result_next = res_reg;
                    o_index_next  = 4'(j_reg);
                    o_last_next   = j_last;
                    if (j_last)
                    begin
                        cnt_next   = '0;
                        max_next   = -17'sd65536;
                        sum_next   = '0;
                        mode_next  = MODE_FWD;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        j_next     = j_reg + CW'(1);
                        state_next = (mode_reg == MODE_JAC) ? ST_JRD : ST_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            max_reg   <= -17'sd65536;
            sum_reg   <= '0;
            mode_reg  <= MODE_FWD;
            j_reg     <= '0;
            pass_reg  <= 1'b0;
            row_reg   <= '0;
            it_reg    <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            max_reg   <= max_next;
            sum_reg   <= sum_next;
            mode_reg  <= mode_next;
            j_reg     <= j_next;
            pass_reg  <= pass_next;
            row_reg   <= row_next;
            it_reg    <= it_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg     <= prod_next;
        term_reg     <= term_next;
        yi_reg       <= yi_next;
        p_reg        <= p_next;
        rem_reg      <= rem_next;
        q_reg        <= q_next;
        res_reg      <= res_next;
        o_result_reg <= o_result_next;
        o_index_reg  <= o_index_next;
        o_last_reg   <= o_last_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[cnt_reg[AW-1:0]] <= q_word.value;
        end
        rd_data_reg <= mem[rd_addr];
    end

endmodule

// File: rtl/core/softmax_with_jacobian_row_core.sv
`timescale 1ns / 1ps
// Softmax / Jacobian row engine. Words load a vector (up to MAX_LEN elements,
// extras dropped) until the word flagged last; mode is taken from the first
// word. Loading takes one word per cycle while the engine is idle, through a
// two-word input queue. At the last word the engine runs: forward mode first
// makes an exponent pass per element for the sum (store read, multiply,
// exponent, accumulate), then per element reads, multiplies and looks up the
// exponent again, runs a serial shift-subtract divide for the 16-bit quotient
// and outputs it (a saturated quotient skips the divide); Jacobian mode
// fetches y_i, then per element does a store read, multiply, round and output.
// A stalled output holds the engine. One result word per element leaves
// through a registered output; while the engine runs the input queue takes
// up to two more words and then stalls.
module softmax_with_jacobian_row_core
    import smj_pkg::*;
#(
    parameter int MAX_LEN        = 16,
    parameter int EXP_TABLE_BITS = 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               valid,
    output logic               stall,
    input  logic               mode,
    input  logic signed [16:0] value,
    input  logic [3:0]         row_index,
    input  logic               last,
    output logic               res_valid,
    input  logic               res_stall,
    output logic signed [17:0] result,
    output logic [3:0]         index,
    output logic               last_res
);

    smj_word_t  q_word;
    logic       q_valid;
    logic       q_pop;
    smj_qstat_t q_stat;

    smj_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid     (valid),
        .stall     (stall),
        .mode      (mode),
        .value     (value),
        .row_index (row_index),
        .last      (last),
        .q_word    (q_word),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_stat    (q_stat)
    );

    smj_back #(
        .MAX_LEN        (MAX_LEN),
        .EXP_TABLE_BITS (EXP_TABLE_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_word    (q_word),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .result    (result),
        .index     (index),
        .last_res  (last_res)
    );

`ifndef SYNTHESIS
    a_queue_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("queue full and empty at once");

    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        (valid && !stall) |=> !q_stat.empty)
        else $error("accepted word missing from queue");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("pop from empty queue");
`endif

endmodule

// File: tb/sv/smj_checker.sv
`timescale 1ns / 1ps
module smj_checker
    import smj_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               valid,
    input  logic               stall,
    input  logic               mode,
    input  logic signed [16:0] value,
    input  logic [3:0]         row_index,
    input  logic               last,
    input  logic               res_valid,
    input  logic               res_stall,
    input  logic signed [17:0] result,
    input  logic [3:0]         index,
    input  logic               last_res,
    output int                 fail_count,
    output int                 pending
);

    localparam int VEC_LEN  = 16;
    localparam int TBL_BITS = 8;

    typedef struct {
        logic signed [17:0] result;
        logic [3:0]         index;
        logic               last_res;
    } smj_res_t;

    smj_res_t           res_q[$];
    logic signed [16:0] vec[VEC_LEN];
    int                 elem_cnt;
    logic signed [16:0] vec_max;
    logic               vec_mode;
    logic [16:0]        frac_tbl[1 << TBL_BITS];

    assign pending = res_q.size();

    // Taylor series of exp(-z) in Q32, rounded into Q16
    function automatic longint unsigned pow2_frac(int unsigned k);
        longint unsigned z;
        longint unsigned term;
        longint          acc;
        logic [127:0]    pr;
        z    = 64'((128'(k) * 128'd2977044472) >> TBL_BITS);
        term = 64'd1 << 32;
        acc  = 64'sd4294967296;
        for (int n = 1; n <= 12; n++)
        begin
            pr   = 128'(term) * 128'(z);
            term = 64'(pr >> 32) / 64'(n);
            if (n % 2 == 1)
            begin
                acc = acc - longint'(term);
            end
            else
            begin
                acc = acc + longint'(term);
            end
        end
        if (acc < 0)
        begin
            acc = 0;
        end
        return ($unsigned(acc) + 32768) >> 16;
    endfunction

    function automatic longint unsigned exp_weight(longint x, longint mx);
        longint          d;
        longint unsigned t;
        longint unsigned n;
        d = mx - x;
        if (d < 0)
        begin
            d = 0;
        end
        t = ($unsigned(d) * 94548 + (64'd1 << (23 - TBL_BITS))) >> (24 - TBL_BITS);
        n = t >> TBL_BITS;
        if (n > 16)
        begin
            return 0;
        end
        return frac_tbl[t & ((1 << TBL_BITS) - 1)] >> n;
    endfunction

    function automatic logic signed [17:0] round_q16(longint p);
        longint r;
        p = p + 32768;
        if (p >= 0)
        begin
            r = p / 65536;
        end
        else
        begin
            r = -((-p + 65535) / 65536);
        end
        if (r < RES_MIN)
        begin
            r = RES_MIN;
        end
        if (r > RES_MAX)
        begin
            r = RES_MAX;
        end
        return 18'(r);
    endfunction

    task automatic predict_vector(logic [3:0] row);
        longint unsigned sum;
        longint unsigned q;
        longint          yi;
        longint          p;
        smj_res_t        r;
        if (vec_mode == MODE_FWD)
        begin
            sum = 0;
            for (int j = 0; j < elem_cnt; j++)
            begin
                sum += exp_weight(vec[j], vec_max);
                if (sum > SUM_MAX)
                begin
                    sum = SUM_MAX;
                end
            end
        end
        yi = (row < elem_cnt) ? longint'(vec[row]) : 0;
        for (int j = 0; j < elem_cnt; j++)
        begin
            if (vec_mode == MODE_FWD)
            begin
                q = (sum != 0) ? (exp_weight(vec[j], vec_max) << 16) / sum : 65535;
                if (q > 65535)
                begin
                    q = 65535;
                end
                r.result = 18'(q);
            end
            else
            begin
                if (j == row)
                begin
                    p = yi * (65536 - yi);
                end
                else
                begin
                    p = -(longint'(vec[j]) * yi);
                end
                r.result = round_q16(p);
            end
            r.index    = 4'(j);
            r.last_res = (j + 1 == elem_cnt);
            res_q.push_back(r);
        end
        elem_cnt = 0;
        vec_max  = -17'sd65536;
        vec_mode = MODE_FWD;
    endtask

    task automatic report(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        fail_count++;
    endtask

    initial
    begin
        fail_count = 0;
        elem_cnt   = 0;
        vec_max    = -17'sd65536;
        vec_mode   = MODE_FWD;
        for (int k = 0; k < (1 << TBL_BITS); k++)
        begin
            frac_tbl[k] = 17'(pow2_frac(k));
        end
    end

    always @(posedge clk)
    begin
        smj_res_t e;
        if (rst_n && valid && !stall)
        begin
            if (elem_cnt == 0)
            begin
                vec_mode = mode;
            end
            if (elem_cnt < VEC_LEN)
            begin
                vec[elem_cnt] = value;
                elem_cnt++;
                if (value > vec_max)
                begin
                    vec_max = value;
                end
            end
            if (last)
            begin
                predict_vector(row_index);
            end
        end
        if (rst_n && res_valid && !res_stall)
        begin
            if (res_q.size() == 0)
            begin
                report("unexpected word index", index, -1);
            end
            else
            begin
                e = res_q.pop_front();
                if (result !== e.result)
                begin
                    report($sformatf("result at %0d", e.index), result, e.result);
                end
                if (index !== e.index)
                begin
                    report("index", index, e.index);
                end
                if (last_res !== e.last_res)
                begin
                    report($sformatf("last_res at %0d", e.index), last_res, e.last_res);
                end
            end
        end
    end

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    import smj_pkg::*;

    logic               clk;
    logic               rst_n;
    logic               valid;
    logic               stall;
    logic               mode;
    logic signed [16:0] value;
    logic [3:0]         row_index;
    logic               last;
    logic               res_valid;
    logic               res_stall;
    logic signed [17:0] result;
    logic [3:0]         index;
    logic               last_res;
    int                 fail_count;
    int                 pending;
    int                 cycles;
    int                 counted;
    logic               calm;
    logic               hold_off;

    softmax_with_jacobian_row_core i_dut (.*);

    smj_checker i_chk (.*);

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > 400000)
            begin
                $display("tb_top failed");
                $finish;
            end
        end
    end

    // receiver: random stalls, a quiet stretch, one long hold-off
    initial
    begin
        res_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                res_stall <= 1'b1;
            end
            else
            begin
                res_stall <= !calm && ($urandom_range(99) < 6);
            end
        end
    end

    task automatic send_word(logic m, logic signed [16:0] v, logic [3:0] r, logic l);
        valid     <= !calm && ($urandom_range(99) < 6) ? 1'b0 : 1'b1;
        mode      <= m;
        value     <= v;
        row_index <= r;
        last      <= l;
        @(posedge clk);
        while (!valid)
        begin
            valid <= !calm && ($urandom_range(99) < 6) ? 1'b0 : 1'b1;
            @(posedge clk);
        end
        while (stall)
        begin
            @(posedge clk);
        end
    endtask

    task automatic send_vector(logic m, int len, int kind, logic [3:0] r);
        logic signed [16:0] v;
        for (int j = 0; j < len; j++)
        begin
            case (kind)
                0: v = 17'($urandom);
                1: v = 17'($urandom_range(65535));
                2: v = 17'($signed($urandom_range(2047)) - 1024);
                default: v = 17'($urandom_range(8192));
            endcase
            send_word(j == 0 ? m : logic'($urandom_range(1)), v, r, j == len - 1);
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        valid     = 1'b0;
        mode      = MODE_FWD;
        value     = '0;
        row_index = '0;
        last      = 1'b0;
        calm      = 1'b0;
        hold_off  = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_word(MODE_FWD, 17'sd1000, 4'd0, 1'b1);
        send_word(MODE_FWD, 17'sd65535, 4'd0, 1'b0);
        send_word(MODE_FWD, -17'sd65536, 4'd0, 1'b0);
        send_word(MODE_FWD, 17'sd0, 4'd0, 1'b1);
        send_word(MODE_FWD, 17'sd256, 4'd0, 1'b0);
        send_word(MODE_JAC, 17'sd256, 4'd0, 1'b1);
        send_word(MODE_JAC, 17'sd65535, 4'd15, 1'b0);
        send_word(MODE_FWD, -17'sd65536, 4'd15, 1'b0);
        send_word(MODE_FWD, 17'sd32768, 4'd1, 1'b1);
        send_word(MODE_JAC, 17'sd16384, 4'd0, 1'b0);
        send_word(MODE_JAC, 17'sd49152, 4'd5, 1'b1);
        send_vector(MODE_FWD, 18, 2, 4'd0);
        send_vector(MODE_JAC, 17, 1, 4'd15);
        calm = 1'b1;
        hold_off = 1'b1;
        fork
            send_vector(MODE_JAC, 14, 3, 4'd3);
            begin
                repeat (600) @(posedge clk);
                hold_off = 1'b0;
            end
        join
        send_vector(MODE_FWD, 8, 2, 4'd2);
        calm = 1'b0;
        while (cycles < 1000000)
        begin
            send_vector(logic'($urandom_range(1)), $urandom_range(1, 6),
                        $urandom_range(3), 4'($urandom_range(7)));
            if ($urandom_range(99) < 8)
            begin
                send_vector(logic'($urandom_range(1)), 16, $urandom_range(3),
                            4'($urandom));
            end
            if (counted >= 120)
            begin
                break;
            end
        end
        valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (50) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("tb_top passed");
        end
        else
        begin
            $display("tb_top failed");
        end
        $finish;
    end

    initial counted = 0;
    always @(posedge clk)
    begin
        if (rst_n && valid && !stall)
        begin
            counted <= counted + 1;
        end
    end

endmodule

// File: softmax_with_jacobian_row_core.f
rtl/core/smj_pkg.sv
rtl/core/smj_front.sv
rtl/core/smj_back.sv
rtl/core/softmax_with_jacobian_row_core.sv
tb/sv/smj_checker.sv
tb/sv/tb_top.sv
